### hdl/pmf5_pkg.sv
// Package for the five-tap pseudo-median filter.
// Holds the sample width, the sample type and the three-input min/max helpers.
// No dependencies.
package pmf5_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned WIN_DEPTH    = 5;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SAMPLE_WIDTH:0]   sum_t;

  function automatic sample_t min3(input sample_t a, input sample_t b, input sample_t c);
    sample_t m;
    m = (a < b) ? a : b;
    return (m > c) ? c : m;
  endfunction

  function automatic sample_t max3(input sample_t a, input sample_t b, input sample_t c);
    sample_t m;
    m = (a > b) ? a : b;
    return (m < c) ? c : m;
  endfunction

endpackage

### hdl/pmf5_in_if.sv
// Input channel of the pseudo-median filter: valid/ready and one sample.
// Depends on pmf5_pkg.
interface pmf5_in_if
  import pmf5_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### hdl/pmf5_out_if.sv
// Output channel of the pseudo-median filter: valid/ready and one result.
// Depends on pmf5_pkg.
interface pmf5_out_if
  import pmf5_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

### hdl/pseudo_median_filter_5_unit.sv
// Top level of the five-tap pseudo-median filter.
// Depends on pmf5_pkg, pmf5_in_if and pmf5_out_if.
//
// Usage:
// - sample_i carries one signed sample per transaction; filtered_o carries
//   one filtered result per transaction, in the same order.
// - Each accepted sample is shifted into a five-entry window register. The
//   result is the floor average of the largest three-sample minimum and the
//   smallest three-sample maximum over the window.
// - A sample accepted into the window register yields its result through
//   two register stages (window/input register, result register).
// - Throughput: one sample per cycle unless the receiver stalls, set by the
//   single comparator network between the window and result registers.
// - Reset clears the window to zeros and drops any work in flight; the
//   zero entries take part in the first four results like real samples.
// - When the receiver stalls, the result register holds, the window stage
//   holds behind it, and sample_i.ready drops once both are full.
module pseudo_median_filter_5_unit
  import pmf5_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  pmf5_in_if.sink           sample_i,
  pmf5_out_if.source        filtered_o
);

  sample_t win_q [WIN_DEPTH];
  logic    win_valid_q;
  sample_t out_q;
  logic    out_valid_q;

  logic    out_adv;
  logic    win_adv;
  logic    in_acc;
  sample_t lo;
  sample_t hi;
  sum_t    sum;
  sample_t filt_d;

  assign out_adv = !out_valid_q || filtered_o.ready;
  assign win_adv = win_valid_q && out_adv;
  assign sample_i.ready = !win_valid_q || out_adv;
  assign in_acc  = sample_i.valid && sample_i.ready;

  always_comb begin
    lo = max3(min3(win_q[0], win_q[1], win_q[2]),
              min3(win_q[1], win_q[2], win_q[3]),
              min3(win_q[2], win_q[3], win_q[4]));
    hi = min3(max3(win_q[0], win_q[1], win_q[2]),
              max3(win_q[1], win_q[2], win_q[3]),
              max3(win_q[2], win_q[3], win_q[4]));
    sum    = sum_t'(lo) + sum_t'(hi);
    filt_d = sample_t'(sum >>> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_q[k] <= '0;
      end
      win_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        win_q[0] <= sample_i.sample;
        for (int k = 1; k < WIN_DEPTH; k++) begin
          win_q[k] <= win_q[k-1];
        end
      end
      if (sample_i.ready) begin
        win_valid_q <= sample_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= win_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (win_adv) begin
      out_q <= filt_d;
    end
  end

  assign filtered_o.valid    = out_valid_q;
  assign filtered_o.filtered = out_q;

  a_lo_le_hi : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_valid_q |-> (lo <= hi))
    else $error("max of minima exceeds min of maxima");

  a_win_shift : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (win_q[1] == $past(win_q[0])) && (win_q[4] == $past(win_q[3])))
    else $error("window did not shift on accepted sample");

  a_win_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_valid_q && !out_adv) |=> win_valid_q && $stable(win_q[0]))
    else $error("window stage lost a stalled sample");

  a_result_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_adv |=> out_valid_q && (out_q == $past(filt_d)))
    else $error("result register not loaded from window stage");

endmodule
